### sv/sha256_pkg.sv
package sha256_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned NumH   = 8;
    localparam int unsigned NumW   = 16;
    localparam int unsigned Rounds = 64;
    localparam int unsigned CountW = 64;

    typedef logic [WordW-1:0] t_word;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    localparam t_word ROUND_K [Rounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word INIT_H [NumH] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic t_word big_sigma0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

### sv/sha256_ifs.sv
interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;

    modport source(output valid, output data_byte, output has_byte,
                   output end_of_message, input ready);
    modport sink(input valid, input data_byte, input has_byte,
                 input end_of_message, output ready);
endinterface

interface sha256_out_if
    import sha256_pkg::*;
;
    logic  valid;
    logic  ready;
    t_word digest_word;
    logic  digest_last;

    modport source(output valid, output digest_word, output digest_last, input ready);
    modport sink(input valid, input digest_word, input digest_last, output ready);
endinterface

### sv/sha256_byte_stream_hasher_core.sv
// A byte beat is taken only while the core is idle; the beat that completes a 64-byte
// block keeps the input busy through the compression rounds and the fold into the chain value.
// End of message: the padding state, one or two blocks (plus a state that builds a
// length-only block), then eight digest beats, one per accepted cycle.
// No new byte is taken while a block is compressed or while the digest is sent out.
// Reset (synchronous, active low) loads the initial hash values and clears the count.
module sha256_byte_stream_hasher_core
    import sha256_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    sha256_in_if.sink     i_byte,
    sha256_out_if.source  o_digest
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_COMP = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_PAD  = 3'd3;
    localparam logic [2:0] S_LEN  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]        r_state;
    logic [2:0]        r_after;
    logic [5:0]        r_round;
    logic [2:0]        r_oidx;
    logic [CountW-1:0] r_count;
    t_word             r_h [NumH];
    t_word             r_v [NumH];
    t_word             r_w [NumW];

    logic        accept;
    logic [5:0]  pos;
    logic [3:0]  wi;
    logic [1:0]  lane;
    t_word       s1, ch, t1, s0, maj, t2, w_next;
    logic [CountW-1:0] bit_len;

    assign i_byte.ready = (r_state == S_IDLE);
    assign accept       = i_byte.valid && (r_state == S_IDLE);
    assign pos          = r_count[5:0];
    assign wi           = pos[5:2];
    assign lane         = pos[1:0];
    assign bit_len      = {r_count[CountW-4:0], 3'b000};

    assign o_digest.valid       = (r_state == S_OUT);
    assign o_digest.digest_word = r_h[0];
    assign o_digest.digest_last = (r_oidx == 3'd7);

    // One SHA-256 round on the working variables, and the next schedule word.
    always_comb begin
        s1     = big_sigma1(r_v[4]);
        ch     = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1     = r_v[7] + s1 + ch + ROUND_K[r_round] + r_w[0];
        s0     = big_sigma0(r_v[0]);
        maj    = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2     = s0 + maj;
        w_next = r_w[0] + small_sigma0(r_w[1]) + r_w[9] + small_sigma1(r_w[14]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_after <= S_IDLE;
            r_round <= '0;
            r_oidx  <= '0;
            r_count <= '0;
            for (int i = 0; i < NumH; i++) begin
                r_h[i] <= INIT_H[i];
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_byte.has_byte) begin
                            case (lane)
                                2'd0: r_w[wi] <= {i_byte.data_byte, 24'h0};
                                2'd1: r_w[wi][23:16] <= i_byte.data_byte;
                                2'd2: r_w[wi][15:8] <= i_byte.data_byte;
                                default: r_w[wi][7:0] <= i_byte.data_byte;
                            endcase
                            r_count <= r_count + 1'b1;
                        end
                        if (i_byte.has_byte && pos == 6'd63) begin
                            r_state <= S_COMP;
                            r_after <= i_byte.end_of_message ? S_PAD : S_IDLE;
                            r_round <= '0;
                            r_v     <= r_h;
                        end else if (i_byte.end_of_message) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_COMP: begin
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    for (int i = 0; i < NumW - 1; i++) begin
                        r_w[i] <= r_w[i+1];
                    end
                    r_w[NumW-1] <= w_next;
                    r_round <= r_round + 1'b1;
                    if (r_round == 6'd63) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    for (int i = 0; i < NumH; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                    r_state <= r_after;
                end
                S_PAD: begin
                    // Pad byte goes at the current position; later words clear.
                    case (lane)
                        2'd0: r_w[wi] <= {PAD_BYTE, 24'h0};
                        2'd1: r_w[wi][23:0] <= {PAD_BYTE, 16'h0};
                        2'd2: r_w[wi][15:0] <= {PAD_BYTE, 8'h0};
                        default: r_w[wi][7:0] <= PAD_BYTE;
                    endcase
                    // When the length fits, its two words are loaded below instead.
                    for (int i = 0; i < NumW; i++) begin
                        if (4'(i) > wi && (pos >= LEN_POS || 4'(i) < 4'(NumW - 2))) begin
                            r_w[i] <= '0;
                        end
                    end
                    if (pos < LEN_POS) begin
                        r_w[14] <= bit_len[63:32];
                        r_w[15] <= bit_len[31:0];
                        r_after <= S_OUT;
                    end else begin
                        r_after <= S_LEN;
                    end
                    r_state <= S_COMP;
                    r_round <= '0;
                    r_v     <= r_h;
                end
                S_LEN: begin
                    for (int i = 0; i < NumW - 2; i++) begin
                        r_w[i] <= '0;
                    end
                    r_w[14] <= bit_len[63:32];
                    r_w[15] <= bit_len[31:0];
                    r_after <= S_OUT;
                    r_state <= S_COMP;
                    r_round <= '0;
                    r_v     <= r_h;
                end
                S_OUT: begin
                    // Shifting in the initial values re-arms the chain after the
                    // eighth beat.
                    if (o_digest.ready) begin
                        for (int i = 0; i < NumH - 1; i++) begin
                            r_h[i] <= r_h[i+1];
                        end
                        r_h[NumH-1] <= INIT_H[r_oidx];
                        r_oidx <= r_oidx + 1'b1;
                        if (r_oidx == 3'd7) begin
                            r_state <= S_IDLE;
                            r_count <= '0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### verif/sha256_byte_stream_hasher_core_tb.sv
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_core_tb
    import sha256_pkg::*;
;

    typedef struct packed {
        t_word word;
        logic  last;
    } t_digest_beat;

    // Tracks the running hash of every message seen on the byte channel and holds
    // the digest words still owed by the block.
    class sha256_digest_tracker;
        localparam int LENGTH_FIELD_POS = 56;

        t_word        round_const [64];
        t_word        start_h [8];
        t_word        chain [8];
        logic [7:0]   blk [64];
        logic [63:0]  msg_bytes;
        t_digest_beat digest_words_due [$];
        int           mismatch_count;

        function new();
            round_const = '{
                32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
                32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
                32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
                32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
                32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
                32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
                32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
                32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
                32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
                32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
                32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
                32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
                32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
                32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
                32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
                32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
            };
            start_h = '{
                32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
            };
            chain = start_h;
            foreach (blk[i]) blk[i] = 8'h00;
            msg_bytes = '0;
            mismatch_count = 0;
        endfunction

        function t_word rotr(t_word x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress_block();
            t_word w [64];
            t_word v [8];
            t_word t1;
            t_word t2;
            t_word s0;
            t_word s1;
            for (int r = 0; r < 16; r++) begin
                w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
            end
            for (int r = 16; r < 64; r++) begin
                s0 = rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3);
                s1 = rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10);
                w[r] = s1 + w[r-7] + s0 + w[r-16];
            end
            v = chain;
            for (int r = 0; r < 64; r++) begin
                t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                     + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_const[r] + w[r];
                t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                     + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
        endfunction

        function void absorb_beat(logic [7:0] b, logic h, logic e);
            logic [63:0]  bit_len;
            int           pos;
            t_digest_beat beat;
            if (h) begin
                blk[msg_bytes[5:0]] = b;
                msg_bytes = msg_bytes + 1;
                if (msg_bytes[5:0] == 6'd0) compress_block();
            end
            if (!e) return;
            pos = int'(msg_bytes[5:0]);
            blk[pos] = 8'h80;
            for (int i = pos + 1; i < 64; i++) blk[i] = 8'h00;
            // No room for the length field: close this block and add one more.
            if (pos >= LENGTH_FIELD_POS) begin
                compress_block();
                foreach (blk[i]) blk[i] = 8'h00;
            end
            bit_len = msg_bytes << 3;
            for (int i = 0; i < 8; i++) blk[LENGTH_FIELD_POS + i] = bit_len[63 - 8*i -: 8];
            compress_block();
            for (int i = 0; i < 8; i++) begin
                beat.word = chain[i];
                beat.last = (i == 7);
                digest_words_due = {digest_words_due, beat};
            end
            chain = start_h;
            msg_bytes = '0;
        endfunction

        function void match_digest_word(t_word word, logic last);
            t_digest_beat want;
            if (digest_words_due.size() == 0) begin
                $error("digest_word beat with no digest pending: got %h (digest_last %b)",
                       word, last);
                mismatch_count++;
                return;
            end
            want = digest_words_due.pop_front();
            if (word !== want.word) begin
                $error("digest_word mismatch: expected %h, got %h", want.word, word);
                mismatch_count++;
            end
            if (last !== want.last) begin
                $error("digest_last mismatch: expected %b, got %b", want.last, last);
                mismatch_count++;
            end
        endfunction

        function int pending();
            return digest_words_due.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    sha256_in_if  byte_if ();
    sha256_out_if digest_if ();

    sha256_byte_stream_hasher_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_if),
        .o_digest (digest_if)
    );

    sha256_digest_tracker tracker = new();

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_left      = 0;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (byte_if.valid && byte_if.ready) begin
                tracker.absorb_beat(byte_if.data_byte, byte_if.has_byte,
                                    byte_if.end_of_message);
            end
            if (digest_if.valid && digest_if.ready) begin
                tracker.match_digest_word(digest_if.digest_word, digest_if.digest_last);
            end
        end
    end

    // Digest receiver; a long hold-off takes priority over random stalls.
    initial begin
        digest_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                digest_if.ready <= 1'b0;
                hold_left--;
            end else begin
                digest_if.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    initial begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(input logic [7:0] b, input logic h, input logic e);
        while ($urandom_range(99) < src_idle_pct) begin
            byte_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        byte_if.valid          <= 1'b1;
        byte_if.data_byte      <= b;
        byte_if.has_byte       <= h;
        byte_if.end_of_message <= e;
        @(posedge i_clk);
        while (!byte_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Random message of len bytes with stray empty beats mixed in. The end mark rides
    // on the last byte or comes on a beat of its own.
    task automatic send_message(input int len, inout int beats);
        bit mark_on_byte;
        mark_on_byte = (len > 0) && ($urandom_range(3) != 0);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 8) send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
            send_beat(8'($urandom_range(255)), 1'b1, mark_on_byte && (i == len - 1));
            beats++;
        end
        if (!mark_on_byte) begin
            send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
            beats++;
        end
    endtask

    // The sender goes quiet until every owed digest word has come out.
    task automatic drain_digests();
        byte_if.valid <= 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
    endtask

    initial begin
        int beats;
        int long_phase;
        int long_lens [4];
        long_lens = '{55, 56, 63, 64};
        byte_if.valid          = 1'b0;
        byte_if.data_byte      = 8'h00;
        byte_if.has_byte       = 1'b0;
        byte_if.end_of_message = 1'b0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: ignored beats, empty message, "abc", lone bytes at the extremes,
        // end mark on its own beat, a five-byte message, back-to-back empty messages.
        send_beat(8'h5a, 1'b0, 1'b0);
        send_beat(8'hff, 1'b0, 1'b1);
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(8'h62, 1'b1, 1'b0);
        send_beat(8'h63, 1'b1, 1'b1);
        send_beat(8'ha5, 1'b0, 1'b0);
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'hff, 1'b1, 1'b1);
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hff, 1'b1, 1'b0);
        send_beat(8'h80, 1'b1, 1'b0);
        send_beat(8'h7f, 1'b1, 1'b0);
        send_beat(8'h01, 1'b1, 1'b1);
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'hff, 1'b0, 1'b1);

        // Random phases; one of them carries a message long enough to cross the
        // padding boundaries.
        long_phase = $urandom_range(3);
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 55; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 55; end
                default: begin src_idle_pct = 9;  sink_stall_pct = 9;  end
            endcase
            beats = 0;
            if (ph == long_phase) send_message(long_lens[$urandom_range(3)], beats);
            while (beats < 5) send_message($urandom_range(12), beats);
        end

        // Back pressure: hold the receiver off so the block fills and stalls its input.
        src_idle_pct   = 0;
        sink_stall_pct = 20;
        hold_left      = 400;
        beats = 0;
        for (int m = 0; m < 3; m++) send_message($urandom_range(1, 4), beats);
        drain_digests();
        send_message($urandom_range(1, 4), beats);

        drain_digests();
        repeat (100) @(negedge i_clk);
        if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### sha256_byte_stream_hasher_core.f
sv/sha256_pkg.sv
sv/sha256_ifs.sv
sv/sha256_byte_stream_hasher_core.sv
verif/sha256_byte_stream_hasher_core_tb.sv
